// ===== sv/bounding_box_transform_assert.svh =====
// -----------------------------------------------------------------------------
// Bounding box transform assertion macros
// Concurrent check helpers, clocked on clk and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef BOUNDING_BOX_TRANSFORM_ASSERT_SVH
`define BOUNDING_BOX_TRANSFORM_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BBT_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// The consequent must hold in the cycle after the antecedent.
`define BBT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define BBT_ASSERT_NOW(name, ante, cons)
`define BBT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== sv/bbt_pkg.sv =====
// -----------------------------------------------------------------------------
// Bounding box transform package
// Widths, pipeline depths and shared types of the box transform.
// -----------------------------------------------------------------------------
package bbt_pkg;

	localparam int Q_W          = 32;
	localparam int AXES         = 3;
	localparam int CORNER_COUNT = 8;
	localparam int PROD_W       = 48;
	localparam int ACC_W        = 50;
	localparam int MAT_WORDS    = 8;
	localparam int DIV_BITS     = 2;
	localparam int DIV_STAGES   = Q_W / DIV_BITS;
	localparam int LANE_LAT     = DIV_STAGES + 4;
	localparam int MERGE_LAT    = 2;
	localparam int PIPE_DEPTH   = 1 + LANE_LAT + MERGE_LAT + 1;

	localparam logic [Q_W-1:0] Q_ONE = 32'h0001_0000;
	localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

	typedef logic [3:0][3:0][Q_W-1:0] mat_t;              // [row][col]
	typedef logic [AXES-1:0][Q_W-1:0] vec_t;
	typedef vec_t [CORNER_COUNT-1:0] corners_t;
	typedef logic [AXES-1:0][AXES-1:0][PROD_W-1:0] prod3_t; // [col][row]

	typedef struct packed {
		vec_t lo;
		vec_t hi;
		logic pass;
		logic proj;
		vec_t aff_min;
		vec_t aff_max;
		logic aff_err;
	} side_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic ovf;
		logic apos;
		logic aneg;
	} div_flag_t;

endpackage

// ===== sv/bbt_div.sv =====
// -----------------------------------------------------------------------------
// Bounding box transform divider
// Pipelined Q16.16 divide a / w, truncating toward zero, with saturation.
// -----------------------------------------------------------------------------
module bbt_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [bbt_pkg::ACC_W-1:0] a,
	input  logic signed [bbt_pkg::ACC_W-1:0] w,
	output logic [bbt_pkg::Q_W-1:0]        q,
	output logic                           err
);
	localparam int W     = bbt_pkg::ACC_W;
	localparam int REM_W = W + 1;
	localparam int QW    = bbt_pkg::Q_W;
	localparam int NS    = bbt_pkg::DIV_STAGES;

	logic [REM_W-1:0]     rem_sk  [NS+1];
	logic [QW-1:0]        low_sk  [NS+1];
	logic [QW-1:0]        quo_sk  [NS+1];
	logic [W-1:0]         uw_sk   [NS+1];
	bbt_pkg::div_flag_t   flag_sk [NS+1];

	logic [QW-1:0] q_sn;
	logic          err_sn;

	logic [W-1:0] ua, uw;

	assign ua = a[W-1] ? W'(-a) : W'(a);
	assign uw = w[W-1] ? W'(-w) : W'(w);

	// Entry stage: magnitudes, overflow test, and the remainder seeded with ua >> 16.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sk[0]       <= REM_W'(ua >> 16);
			low_sk[0]       <= {ua[15:0], 16'b0};
			quo_sk[0]       <= '0;
			uw_sk[0]        <= uw;
			flag_sk[0].neg  <= a[W-1] ^ w[W-1];
			flag_sk[0].zero <= (w == '0);
			flag_sk[0].ovf  <= ({16'b0, ua} >= {uw, 16'b0});
			flag_sk[0].apos <= !a[W-1] && (a != '0);
			flag_sk[0].aneg <= a[W-1];
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [REM_W-1:0] rem_d;
		logic [QW-1:0]    low_d, quo_d;

		always_comb begin
			rem_d = rem_sk[k];
			low_d = low_sk[k];
			quo_d = quo_sk[k];
			for (int b = 0; b < bbt_pkg::DIV_BITS; b++) begin
				rem_d = {rem_d[REM_W-2:0], low_d[QW-1]};
				low_d = {low_d[QW-2:0], 1'b0};
				if (rem_d >= {1'b0, uw_sk[k]}) begin
					rem_d = rem_d - {1'b0, uw_sk[k]};
					quo_d = {quo_d[QW-2:0], 1'b1};
				end else begin
					quo_d = {quo_d[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1]  <= rem_d;
				low_sk[k+1]  <= low_d;
				quo_sk[k+1]  <= quo_d;
				uw_sk[k+1]   <= uw_sk[k];
				flag_sk[k+1] <= flag_sk[k];
			end
		end
	end

	logic [QW:0]   mag;
	logic [QW-1:0] q_d;
	logic          err_d;

	always_comb begin
		mag   = flag_sk[NS].ovf ? {1'b1, {QW{1'b0}}} : {1'b0, quo_sk[NS]};
		q_d   = mag[QW-1:0];
		err_d = 1'b0;
		if (flag_sk[NS].zero) begin
			err_d = 1'b1;
			if (flag_sk[NS].apos) begin
				q_d = bbt_pkg::Q_MAX;
			end else if (flag_sk[NS].aneg) begin
				q_d = bbt_pkg::Q_MIN;
			end else begin
				q_d = '0;
			end
		end else if (!flag_sk[NS].neg) begin
			if (mag >= {2'b01, {(QW-1){1'b0}}}) begin
				q_d   = bbt_pkg::Q_MAX;
				err_d = 1'b1;
			end
		end else begin
			if (mag > {2'b01, {(QW-1){1'b0}}}) begin
				q_d   = bbt_pkg::Q_MIN;
				err_d = 1'b1;
			end else begin
				q_d = QW'(-mag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_sn   <= q_d;
			err_sn <= err_d;
		end
	end

	assign q   = q_sn;
	assign err = err_sn;

endmodule

// ===== sv/bbt_lane.sv =====
// -----------------------------------------------------------------------------
// Bounding box transform corner lane
// Transforms one box corner by the matrix and divides by its weight.
// -----------------------------------------------------------------------------
module bbt_lane (
	input  logic            clk,
	input  logic            en,
	input  bbt_pkg::vec_t   pt,
	input  bbt_pkg::mat_t   mat,
	output bbt_pkg::prod3_t prod,
	output bbt_pkg::vec_t   res,
	output logic            err
);
	localparam int PW = bbt_pkg::PROD_W;
	localparam int AW = bbt_pkg::ACC_W;

	logic signed [63:0]         mul [4][bbt_pkg::AXES];
	logic [3:0][2:0][PW-1:0]    prod_s2;
	logic signed [AW-1:0]       acc_d [4];
	logic signed [AW-1:0]       acc_s3 [4];
	logic [bbt_pkg::AXES-1:0]   div_err;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			for (int i = 0; i < bbt_pkg::AXES; i++) begin
				mul[j][i] = $signed(pt[i]) * $signed(mat[i][j]);
			end
		end
	end

	// Products are rounded toward minus infinity by dropping the low 16 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				for (int i = 0; i < bbt_pkg::AXES; i++) begin
					prod_s2[j][i] <= mul[j][i][63:16];
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			acc_d[j] = $signed(mat[3][j]) + $signed(prod_s2[j][0])
				+ $signed(prod_s2[j][1]) + $signed(prod_s2[j][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				acc_s3[j] <= acc_d[j];
			end
		end
	end

	for (genvar i = 0; i < bbt_pkg::AXES; i++) begin : g_div
		bbt_div u_div (
			.clk (clk),
			.en  (en),
			.a   (acc_s3[i]),
			.w   (acc_s3[3]),
			.q   (res[i]),
			.err (div_err[i])
		);
	end

	assign prod = prod_s2[2:0];
	assign err  = |div_err;

endmodule

// ===== sv/bbt_affine.sv =====
// -----------------------------------------------------------------------------
// Bounding box transform affine bound
// Builds the affine result from the all-low and all-high corner products.
// -----------------------------------------------------------------------------
module bbt_affine (
	input  bbt_pkg::mat_t   mat,
	input  bbt_pkg::prod3_t plo,
	input  bbt_pkg::prod3_t phi,
	output bbt_pkg::vec_t   vmin,
	output bbt_pkg::vec_t   vmax,
	output logic            err
);
	localparam int AW = bbt_pkg::ACC_W;
	localparam int QW = bbt_pkg::Q_W;
	localparam logic signed [AW-1:0] SAT_HI = {{(AW-QW+1){1'b0}}, {(QW-1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_LO = {{(AW-QW+1){1'b1}}, {(QW-1){1'b0}}};

	always_comb begin
		logic signed [AW-1:0] smin, smax, pa, pb;
		vmin = '0;
		vmax = '0;
		err  = 1'b0;
		for (int i = 0; i < bbt_pkg::AXES; i++) begin
			smin = $signed(mat[3][i]);
			smax = smin;
			for (int j = 0; j < bbt_pkg::AXES; j++) begin
				pa = $signed(plo[i][j]);
				pb = $signed(phi[i][j]);
				if (pa < pb) begin
					smin = smin + pa;
					smax = smax + pb;
				end else begin
					smin = smin + pb;
					smax = smax + pa;
				end
			end
			if (smin > SAT_HI) begin
				vmin[i] = bbt_pkg::Q_MAX;
				err     = 1'b1;
			end else if (smin < SAT_LO) begin
				vmin[i] = bbt_pkg::Q_MIN;
				err     = 1'b1;
			end else begin
				vmin[i] = smin[QW-1:0];
			end
			if (smax > SAT_HI) begin
				vmax[i] = bbt_pkg::Q_MAX;
				err     = 1'b1;
			end else if (smax < SAT_LO) begin
				vmax[i] = bbt_pkg::Q_MIN;
				err     = 1'b1;
			end else begin
				vmax[i] = smax[QW-1:0];
			end
		end
	end

endmodule

// ===== sv/bbt_merge.sv =====
// -----------------------------------------------------------------------------
// Bounding box transform merge
// Reduces the eight corner results to a box and picks the final result.
// -----------------------------------------------------------------------------
module bbt_merge (
	input  logic                              clk,
	input  logic                              en,
	input  bbt_pkg::corners_t                 corner,
	input  logic [bbt_pkg::CORNER_COUNT-1:0]  corner_err,
	input  bbt_pkg::side_t                    side,
	output logic [2*bbt_pkg::AXES*bbt_pkg::Q_W-1:0] data,
	output logic [2:0]                        user
);
	localparam int QW = bbt_pkg::Q_W;

	logic [3:0][bbt_pkg::AXES-1:0][QW-1:0] min_s1, max_s1;
	logic                                   err_s1;
	bbt_pkg::side_t                         side_s1;
	bbt_pkg::vec_t                          min_s2, max_s2;
	logic                                   err_s2;
	bbt_pkg::side_t                         side_s2;

	function automatic logic [QW-1:0] smin(input logic [QW-1:0] x, input logic [QW-1:0] y);
		smin = ($signed(x) < $signed(y)) ? x : y;
	endfunction

	function automatic logic [QW-1:0] smax(input logic [QW-1:0] x, input logic [QW-1:0] y);
		smax = ($signed(x) > $signed(y)) ? x : y;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 4; p++) begin
				for (int i = 0; i < bbt_pkg::AXES; i++) begin
					min_s1[p][i] <= smin(corner[2*p][i], corner[2*p+1][i]);
					max_s1[p][i] <= smax(corner[2*p][i], corner[2*p+1][i]);
				end
			end
			err_s1  <= |corner_err;
			side_s1 <= side;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < bbt_pkg::AXES; i++) begin
				min_s2[i] <= smin(smin(min_s1[0][i], min_s1[1][i]),
					smin(min_s1[2][i], min_s1[3][i]));
				max_s2[i] <= smax(smax(max_s1[0][i], max_s1[1][i]),
					smax(max_s1[2][i], max_s1[3][i]));
			end
			err_s2  <= err_s1;
			side_s2 <= side_s1;
		end
	end

	// Flags from the lowest bit up: passed_through, used_projective, range_error.
	always_comb begin
		if (side_s2.pass) begin
			data = {side_s2.hi, side_s2.lo};
			user = 3'b001;
		end else if (side_s2.proj) begin
			data = {max_s2, min_s2};
			user = {err_s2, 2'b10};
		end else begin
			data = {side_s2.aff_max, side_s2.aff_min};
			user = {side_s2.aff_err, 2'b00};
		end
	end

endmodule

// ===== sv/bounding_box_transform.sv =====
// -----------------------------------------------------------------------------
// Bounding box transform
// Tightest axis-aligned box around a Q16.16 box after a configured 4x4 matrix.
// -----------------------------------------------------------------------------
// One box is taken per clock; the whole pipeline stalls only while the output
// beat is held. Eight corner lanes run in parallel, each with three 16-stage
// dividers that retire two quotient bits per stage, and that divider sets the
// latency. The affine result reuses the products of the all-low and all-high
// corners. Matrix writes are taken at any time but must only happen while no
// box is in flight.
`include "bounding_box_transform_assert.svh"

module bounding_box_transform (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [191:0]  s_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
	input  logic [0:0]    s_tuser,   // assume_affine
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata,   // new_min_x..z, new_max_x..z
	output logic [2:0]    m_tuser,   // passed_through, used_projective, range_error
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	localparam int QW    = bbt_pkg::Q_W;
	localparam int DEPTH = bbt_pkg::PIPE_DEPTH;
	localparam int SIDE_N = bbt_pkg::LANE_LAT - 1;

	logic [bbt_pkg::MAT_WORDS-1:0][63:0] mat_word_q;
	bbt_pkg::mat_t                       mat;
	logic [DEPTH-1:0]                    vld_q;
	logic                                en;

	// Matrix registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_word_q[0] <= 64'h0000_0001_0000_0000;
			mat_word_q[1] <= 64'h0;
			mat_word_q[2] <= 64'h0001_0000_0000_0000;
			mat_word_q[3] <= 64'h0;
			mat_word_q[4] <= 64'h0;
			mat_word_q[5] <= 64'h0000_0001_0000_0000;
			mat_word_q[6] <= 64'h0;
			mat_word_q[7] <= 64'h0001_0000_0000_0000;
		end else if (cfg_valid && (cfg_index < bbt_pkg::MAT_WORDS)) begin
			mat_word_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign mat[r][c] = mat_word_q[(r*4+c)/2][(c%2)*32 +: 32];
		end
	end

	// Pipeline control: every stage moves when the output beat is free or taken.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// Input decode.
	bbt_pkg::vec_t lo_in, hi_in;
	logic          empty_in, inf_in, affine_col, proj_in;

	assign lo_in = s_tdata[95:0];
	assign hi_in = s_tdata[191:96];

	always_comb begin
		empty_in = 1'b0;
		inf_in   = 1'b1;
		for (int i = 0; i < bbt_pkg::AXES; i++) begin
			if ($signed(hi_in[i]) < $signed(lo_in[i])) begin
				empty_in = 1'b1;
			end
			if ((lo_in[i] != bbt_pkg::Q_MIN) || (hi_in[i] != bbt_pkg::Q_MAX)) begin
				inf_in = 1'b0;
			end
		end
	end

	assign affine_col = (mat[0][3] == '0) && (mat[1][3] == '0) && (mat[2][3] == '0)
		&& (mat[3][3] == bbt_pkg::Q_ONE);
	assign proj_in = !s_tuser[0] && !affine_col;

	bbt_pkg::side_t side_s1, side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.lo      <= lo_in;
			side_s1.hi      <= hi_in;
			side_s1.pass    <= empty_in || inf_in;
			side_s1.proj    <= proj_in;
			side_s1.aff_min <= '0;
			side_s1.aff_max <= '0;
			side_s1.aff_err <= 1'b0;
			side_s2         <= side_s1;
		end
	end

	// Corner lanes.
	bbt_pkg::corners_t                pt;
	bbt_pkg::corners_t                corner;
	logic [bbt_pkg::CORNER_COUNT-1:0] corner_err;
	bbt_pkg::prod3_t                  prod [bbt_pkg::CORNER_COUNT];

	for (genvar k = 0; k < bbt_pkg::CORNER_COUNT; k++) begin : g_lane
		for (genvar a = 0; a < bbt_pkg::AXES; a++) begin : g_pt
			assign pt[k][a] = (((k >> (2 - a)) & 1) != 0) ? side_s1.hi[a] : side_s1.lo[a];
		end

		bbt_lane u_lane (
			.clk  (clk),
			.en   (en),
			.pt   (pt[k]),
			.mat  (mat),
			.prod (prod[k]),
			.res  (corner[k]),
			.err  (corner_err[k])
		);
	end

	// Affine result from the all-low and all-high corners.
	bbt_pkg::vec_t aff_min, aff_max;
	logic          aff_err;

	bbt_affine u_affine (
		.mat  (mat),
		.plo  (prod[0]),
		.phi  (prod[bbt_pkg::CORNER_COUNT-1]),
		.vmin (aff_min),
		.vmax (aff_max),
		.err  (aff_err)
	);

	// Side information travels alongside the lanes.
	bbt_pkg::side_t side_aff;
	bbt_pkg::side_t side_sk [SIDE_N];

	always_comb begin
		side_aff         = side_s2;
		side_aff.aff_min = aff_min;
		side_aff.aff_max = aff_max;
		side_aff.aff_err = aff_err;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sk[0] <= side_aff;
			for (int s = 1; s < SIDE_N; s++) begin
				side_sk[s] <= side_sk[s-1];
			end
		end
	end

	logic [191:0] merge_data;
	logic [2:0]   merge_user;

	bbt_merge u_merge (
		.clk        (clk),
		.en         (en),
		.corner     (corner),
		.corner_err (corner_err),
		.side       (side_sk[SIDE_N-1]),
		.data       (merge_data),
		.user       (merge_user)
	);

	// Output register.
	logic [191:0] data_q;
	logic [2:0]   user_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= merge_data;
			user_q <= merge_user;
		end
	end

	assign m_tdata = data_q;
	assign m_tuser = user_q;

	`BBT_ASSERT_NOW(a_pass_clean, m_tvalid && m_tuser[0], !m_tuser[1] && !m_tuser[2])
	`BBT_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_q))
	`BBT_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_q[0])
	`BBT_ASSERT_NEXT(a_bad_index, cfg_valid && (cfg_index >= bbt_pkg::MAT_WORDS), $stable(mat_word_q))

endmodule
